>>> hdl/fcc_lattice_neighbor_count_top_macros.svh
// Assertion macros shared by the lattice neighbor counter.
`ifndef FCC_LATTICE_NEIGHBOR_COUNT_TOP_MACROS_SVH
`define FCC_LATTICE_NEIGHBOR_COUNT_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FCCNC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define FCCNC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/fccnc_pkg.sv
`default_nettype none
package fccnc_pkg;

  localparam int HALF_SIDE_DEF = 8;

  // Site read plus twelve neighbor reads per query.
  localparam int STEPS   = 13;
  localparam int STEP_W  = $clog2(STEPS);
  localparam int COORD_W = 9;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic signed [1:0] dx;
    logic signed [1:0] dy;
    logic signed [1:0] dz;
  } nbr_off_t;

  // Step zero addresses the site itself.
  function automatic nbr_off_t nbr_off(input logic [STEP_W-1:0] step);
    nbr_off_t o;
    unique case (step)
      4'd0:    o = '{dx:  2'sd0, dy:  2'sd0, dz:  2'sd0};
      4'd1:    o = '{dx: -2'sd1, dy: -2'sd1, dz:  2'sd0};
      4'd2:    o = '{dx: -2'sd1, dy:  2'sd1, dz:  2'sd0};
      4'd3:    o = '{dx:  2'sd1, dy: -2'sd1, dz:  2'sd0};
      4'd4:    o = '{dx:  2'sd1, dy:  2'sd1, dz:  2'sd0};
      4'd5:    o = '{dx:  2'sd0, dy: -2'sd1, dz:  2'sd1};
      4'd6:    o = '{dx: -2'sd1, dy:  2'sd0, dz:  2'sd1};
      4'd7:    o = '{dx:  2'sd1, dy:  2'sd0, dz:  2'sd1};
      4'd8:    o = '{dx:  2'sd0, dy:  2'sd1, dz:  2'sd1};
      4'd9:    o = '{dx:  2'sd0, dy: -2'sd1, dz: -2'sd1};
      4'd10:   o = '{dx: -2'sd1, dy:  2'sd0, dz: -2'sd1};
      4'd11:   o = '{dx:  2'sd1, dy:  2'sd0, dz: -2'sd1};
      4'd12:   o = '{dx:  2'sd0, dy:  2'sd1, dz: -2'sd1};
      default: o = '{dx:  2'sd0, dy:  2'sd0, dz:  2'sd0};
    endcase
    return o;
  endfunction

endpackage
`default_nettype wire

>>> hdl/fcc_lattice_neighbor_count_top.sv
`default_nettype none
// Occupancy map of a (2*HALF_SIDE)^3 cube with FCC nearest-neighbor queries.
// A write word stores its bit straight into the map when it is accepted.
// A query word reads the site and its twelve neighbors from the single-port
// occupancy memory, one read per cycle; after the last read the result passes
// S_WAIT and S_FINISH and is loaded once the output is free. The next word is
// taken once the block is back in idle, even while that result still waits to
// be taken. After reset the map is cleared one entry per cycle, all
// 2**(3*clog2(2*HALF_SIDE)) entries (4096 at the default size); no word is
// accepted during that pass.
`include "fcc_lattice_neighbor_count_top_macros.svh"
module fcc_lattice_neighbor_count_top
  import fccnc_pkg::*;
#(
  parameter int HALF_SIDE = HALF_SIDE_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       cmd,
  input  wire logic [3:0] pos_x,
  input  wire logic [3:0] pos_y,
  input  wire logic [3:0] pos_z,
  input  wire logic       occupied_in,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [3:0]      neighbor_count,
  output logic            occupied_out,
  output logic            even_site
);

  localparam int SIDE  = 2 * HALF_SIDE;
  localparam int CW    = (SIDE > 1) ? $clog2(SIDE) : 1;
  localparam int AW    = 3 * CW;
  localparam int DEPTH = 1 << AW;
  localparam logic signed [COORD_W-1:0] SIDE_C = COORD_W'(SIDE);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS - 1);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_QUERY, S_WAIT, S_FINISH} state_t;

  typedef logic signed [COORD_W-1:0] coord_t;

  state_t              state;
  logic [AW-1:0]       clr_addr;
  logic [STEP_W-1:0]   step;
  coord_t              sx, sy, sz;
  logic                q_even;
  logic                q_inside;
  logic [3:0]          cnt;
  logic                occ;
  logic                rd_vld;
  logic                rd_site;
  logic                rd_data;

  logic                mem [DEPTH];
  logic [AW-1:0]       mem_addr;
  logic                mem_we;
  logic                mem_wd;

  coord_t              ix, iy, iz;
  coord_t              nx, ny, nz;
  nbr_off_t            off;
  logic                in_inside;
  logic                n_inside;
  logic                accept;
  logic                res_load;

  function automatic logic in_cube(input coord_t c);
    return (c >= 0) && (c < SIDE_C);
  endfunction

  assign ix = {{(COORD_W-4){1'b0}}, pos_x};
  assign iy = {{(COORD_W-4){1'b0}}, pos_y};
  assign iz = {{(COORD_W-4){1'b0}}, pos_z};
  assign in_inside = in_cube(ix) && in_cube(iy) && in_cube(iz);

  assign off = nbr_off(step);
  assign nx = sx + COORD_W'(off.dx);
  assign ny = sy + COORD_W'(off.dy);
  assign nz = sz + COORD_W'(off.dz);
  assign n_inside = in_cube(nx) && in_cube(ny) && in_cube(nz);

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign res_load = (state == S_FINISH) && (!out_valid || !out_stall);

  always_comb begin
    mem_we   = 1'b0;
    mem_wd   = 1'b0;
    mem_addr = {nx[CW-1:0], ny[CW-1:0], nz[CW-1:0]};
    unique case (state)
      S_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_addr;
      end
      S_IDLE: begin
        mem_we   = accept && (cmd == CMD_WRITE) && in_inside;
        mem_wd   = occupied_in;
        mem_addr = {ix[CW-1:0], iy[CW-1:0], iz[CW-1:0]};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wd;
    end
    rd_data <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      step      <= '0;
      rd_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !res_load) begin
        out_valid <= 1'b0;
      end

      // Fold in the word read last cycle.
      if (rd_vld) begin
        if (rd_site) begin
          occ <= rd_data;
        end else begin
          cnt <= cnt + 4'(rd_data);
        end
      end
      if (state != S_QUERY) begin
        rd_vld <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept && (cmd == CMD_QUERY)) begin
            sx       <= ix;
            sy       <= iy;
            sz       <= iz;
            q_even   <= ~(pos_x[0] ^ pos_y[0] ^ pos_z[0]);
            q_inside <= in_inside;
            cnt      <= '0;
            occ      <= 1'b0;
            step     <= '0;
            state    <= S_QUERY;
          end
        end
        S_QUERY: begin
          // Neighbors count only for an even site inside the cube.
          rd_vld  <= n_inside && ((step == '0) || (q_even && q_inside));
          rd_site <= (step == '0);
          if (step == LAST_STEP) begin
            state <= S_WAIT;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_WAIT: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (res_load) begin
            out_valid      <= 1'b1;
            neighbor_count <= cnt;
            occupied_out   <= occ;
            even_site      <= q_even;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
    end
  end

  `FCCNC_ASSERT_NOW(a_count_range, out_valid, neighbor_count <= 4'd12, "count above twelve")
  `FCCNC_ASSERT_NOW(a_odd_zero, out_valid && !even_site, neighbor_count == 4'd0, "odd site count")
  `FCCNC_ASSERT_NEXT(a_result_load, res_load, out_valid && (state == S_IDLE), "result not loaded")
  `FCCNC_ASSERT_NOW(a_step_range, state == S_QUERY, step <= LAST_STEP, "step out of range")

endmodule
`default_nettype wire
